### sv/cbrf_pkg.sv
// shared types and constants of the cubic bisection root finder
package cbrf_pkg;

  localparam int FracBitsDefault = 16;
  localparam int MaxStepsDefault = 64;
  localparam int XW   = 32;
  localparam int AccW = 4 * XW;
  localparam int StepW = 7;
  localparam int TolW = 31;
  localparam int CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_COEF_CUBIC  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_COEF_SQUARE = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_COEF_LINEAR = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_COEF_CONST  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_TOLERANCE   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_ITER_CAP    = 3'd5;

  typedef struct packed {
    logic signed [XW-1:0] interval_low;
    logic signed [XW-1:0] interval_high;
  } in_item_t;

  typedef struct packed {
    logic signed [XW-1:0] root;
    logic                 converged;
    logic [StepW-1:0]     steps_taken;
  } out_item_t;

  typedef struct packed {
    logic signed [XW-1:0] a;
    logic signed [XW-1:0] b;
    logic signed [XW-1:0] c;
    logic signed [XW-1:0] d;
  } coef_t;

  typedef enum logic [1:0] {
    EV_IDLE,
    EV_START,
    EV_WAIT
  } ev_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL_LO,
    ST_WAIT_LO,
    ST_MID,
    ST_EVAL_MID,
    ST_WAIT_MID,
    ST_OUT
  } state_t;

endpackage

### sv/cubic_bisection_root_finder.sv
// cubic bisection root finder: one f(x) evaluation is 3 serial products (Horner) on the
// one-bit-a-cycle multiplier; f(lo) is evaluated once per item, f(mid) once per step
// one item at a time; the next beat is taken once the FSM has returned to idle
// a new item is taken while the previous result waits in the output reg
// synchronous reset restores the register defaults: a=0 b=0 c=1.0 d=0 tol=66 cap=48
module cubic_bisection_root_finder #(
  parameter int FRAC_BITS = cbrf_pkg::FracBitsDefault,
  parameter int MAX_STEPS = cbrf_pkg::MaxStepsDefault
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  cbrf_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output cbrf_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [cbrf_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [cbrf_pkg::XW-1:0]           cfg_data
);

  localparam int XW = cbrf_pkg::XW;
  localparam int AccW = cbrf_pkg::AccW;
  localparam int StepW = cbrf_pkg::StepW;
  localparam logic [StepW-1:0] MaxSteps = StepW'(MAX_STEPS);

  cbrf_pkg::state_t state, state_next;
  cbrf_pkg::coef_t               coef;
  logic [cbrf_pkg::TolW-1:0]     tolerance;
  logic [StepW-1:0]              iteration_cap;
  logic [StepW-1:0]              cap_eff;

  logic signed [XW-1:0]          lo, hi, mid;
  logic signed [XW:0]            sum;
  logic signed [XW-1:0]          ev_x;
  logic [StepW-1:0]              steps;
  logic                          lo_neg, lo_pos;
  logic                          ev_start, ev_done;
  logic [AccW-1:0]               ev_f;
  logic                          fm_neg, fm_pos;
  logic [AccW-1:0]               mag, tol_sh;
  logic                          met, flip;
  logic                          conv;

  cbrf_eval #(.FRAC_BITS(FRAC_BITS)) u_eval (
    .clk   (clk),
    .rst   (rst),
    .start (ev_start),
    .x     (ev_x),
    .coef  (coef),
    .done  (ev_done),
    .f     (ev_f)
  );

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      coef.a        <= '0;
      coef.b        <= '0;
      coef.c        <= XW'(1) << FRAC_BITS;
      coef.d        <= '0;
      tolerance     <= cbrf_pkg::TolW'(66);
      iteration_cap <= StepW'(48);
    end else if (cfg_we) begin
      case (cfg_index)
        cbrf_pkg::REG_COEF_CUBIC:  coef.a        <= cfg_data;
        cbrf_pkg::REG_COEF_SQUARE: coef.b        <= cfg_data;
        cbrf_pkg::REG_COEF_LINEAR: coef.c        <= cfg_data;
        cbrf_pkg::REG_COEF_CONST:  coef.d        <= cfg_data;
        cbrf_pkg::REG_TOLERANCE:   tolerance     <= cfg_data[cbrf_pkg::TolW-1:0];
        cbrf_pkg::REG_ITER_CAP:    iteration_cap <= cfg_data[StepW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (iteration_cap == '0) cap_eff = StepW'(1);
    else if (iteration_cap > MaxSteps) cap_eff = MaxSteps;
    else cap_eff = iteration_cap;
  end

  // floor of the half sum is an arithmetic shift
  assign sum = {lo[XW-1], lo} + {hi[XW-1], hi};

  assign fm_neg = ev_f[AccW-1];
  assign fm_pos = !ev_f[AccW-1] && (ev_f != '0);
  assign mag    = fm_neg ? (~ev_f + 1'b1) : ev_f;
  assign tol_sh = {{(AccW-cbrf_pkg::TolW){1'b0}}, tolerance} << (3 * FRAC_BITS);
  assign met    = (mag <= tol_sh);
  assign flip   = (lo_neg && fm_pos) || (lo_pos && fm_neg);

  always_comb begin
    state_next = state;
    ev_start   = 1'b0;
    in_ready   = 1'b0;
    case (state)
      cbrf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = cbrf_pkg::ST_EVAL_LO;
      end
      cbrf_pkg::ST_EVAL_LO: begin
        ev_start   = 1'b1;
        state_next = cbrf_pkg::ST_WAIT_LO;
      end
      cbrf_pkg::ST_WAIT_LO:  if (ev_done) state_next = cbrf_pkg::ST_MID;
      cbrf_pkg::ST_MID:      state_next = cbrf_pkg::ST_EVAL_MID;
      cbrf_pkg::ST_EVAL_MID: begin
        ev_start   = 1'b1;
        state_next = cbrf_pkg::ST_WAIT_MID;
      end
      cbrf_pkg::ST_WAIT_MID: begin
        if (ev_done) begin
          if (met || steps == cap_eff) state_next = cbrf_pkg::ST_OUT;
          else state_next = cbrf_pkg::ST_MID;
        end
      end
      cbrf_pkg::ST_OUT: if (!out_valid || out_ready) state_next = cbrf_pkg::ST_IDLE;
      default: state_next = cbrf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cbrf_pkg::ST_IDLE;
      out_valid <= 1'b0;
      steps     <= '0;
    end else begin
      state <= state_next;
      if (state == cbrf_pkg::ST_IDLE && in_valid) steps <= '0;
      if (state == cbrf_pkg::ST_MID) steps <= steps + 1'b1;
      if (state == cbrf_pkg::ST_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      cbrf_pkg::ST_IDLE: begin
        if (in_valid) begin
          lo   <= in_data.interval_low;
          hi   <= in_data.interval_high;
          ev_x <= in_data.interval_low;
        end
      end
      cbrf_pkg::ST_WAIT_LO: begin
        if (ev_done) begin
          lo_neg <= fm_neg;
          lo_pos <= fm_pos;
        end
      end
      cbrf_pkg::ST_MID: begin
        mid  <= sum[XW:1];
        ev_x <= sum[XW:1];
      end
      cbrf_pkg::ST_WAIT_MID: begin
        if (ev_done && !met) begin
          if (flip) begin
            hi <= mid;
          end else begin
            lo     <= mid;
            lo_neg <= fm_neg;
            lo_pos <= fm_pos;
          end
          conv <= 1'b0;
        end else if (ev_done) begin
          conv <= 1'b1;
        end
      end
      cbrf_pkg::ST_OUT: begin
        if (!out_valid || out_ready) begin
          out_data.root        <= mid;
          out_data.converged   <= conv;
          out_data.steps_taken <= steps;
        end
      end
      default: ;
    endcase
  end

  a_steps_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.steps_taken != '0) && (out_data.steps_taken <= MaxSteps))
    else $error("steps_taken out of range");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == cbrf_pkg::ST_EVAL_LO))
    else $error("accepted beat did not start evaluation");

  a_steps_capped: assert property (@(posedge clk) disable iff (rst)
    (state == cbrf_pkg::ST_WAIT_MID) |-> (steps != '0) && (steps <= cap_eff))
    else $error("step counter beyond cap");

endmodule

### sv/cbrf_mul.sv
// bit-serial signed multiplier: wide multiplicand times 32-bit multiplier, one bit a cycle
module cbrf_mul (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [cbrf_pkg::AccW-1:0]            mcand_in,
  input  logic [cbrf_pkg::XW-1:0]              mplier_in,
  output logic                                 done,
  output logic [cbrf_pkg::AccW-1:0]            product
);

  localparam int CntW = $clog2(cbrf_pkg::XW);
  localparam logic [CntW-1:0] LastBit = CntW'(cbrf_pkg::XW - 1);

  logic                        busy;
  logic [CntW-1:0]             cnt;
  logic [cbrf_pkg::AccW-1:0]   acc;
  logic [cbrf_pkg::AccW-1:0]   acc_next;
  logic [cbrf_pkg::AccW-1:0]   mcand;
  logic [cbrf_pkg::XW-1:0]     mplier;

  // the top multiplier bit carries negative weight
  always_comb begin
    acc_next = (cnt == LastBit) ? acc - mcand : acc + mcand;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LastBit) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mcand  <= mcand_in;
      mplier <= mplier_in;
    end else if (busy) begin
      if (mplier[0]) acc <= acc_next;
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

  assign product = acc;

endmodule

### sv/cbrf_eval.sv
// horner evaluation of the cubic, scaled by 2^(4*frac_bits), on one serial multiplier
module cbrf_eval #(
  parameter int FRAC_BITS = cbrf_pkg::FracBitsDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [cbrf_pkg::XW-1:0] x,
  input  cbrf_pkg::coef_t               coef,
  output logic                          done,
  output logic [cbrf_pkg::AccW-1:0]     f
);

  localparam logic [1:0] LastTerm = 2'd2;

  cbrf_pkg::ev_state_t state, state_next;
  logic [1:0]                    k;
  logic [cbrf_pkg::AccW-1:0]     h;
  logic [cbrf_pkg::AccW-1:0]     addend;
  logic                          mul_start;
  logic                          mul_done;
  logic [cbrf_pkg::AccW-1:0]     product;

  cbrf_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .start     (mul_start),
    .mcand_in  (h),
    .mplier_in (x),
    .done      (mul_done),
    .product   (product)
  );

  always_comb begin
    case (k)
      2'd0:    addend = {{(cbrf_pkg::AccW-cbrf_pkg::XW){coef.b[cbrf_pkg::XW-1]}}, coef.b}
                        << FRAC_BITS;
      2'd1:    addend = {{(cbrf_pkg::AccW-cbrf_pkg::XW){coef.c[cbrf_pkg::XW-1]}}, coef.c}
                        << (2 * FRAC_BITS);
      default: addend = {{(cbrf_pkg::AccW-cbrf_pkg::XW){coef.d[cbrf_pkg::XW-1]}}, coef.d}
                        << (3 * FRAC_BITS);
    endcase
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    case (state)
      cbrf_pkg::EV_IDLE:  if (start) state_next = cbrf_pkg::EV_START;
      cbrf_pkg::EV_START: begin
        mul_start  = 1'b1;
        state_next = cbrf_pkg::EV_WAIT;
      end
      cbrf_pkg::EV_WAIT: begin
        if (mul_done) begin
          state_next = (k == LastTerm) ? cbrf_pkg::EV_IDLE : cbrf_pkg::EV_START;
        end
      end
      default: state_next = cbrf_pkg::EV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cbrf_pkg::EV_IDLE;
      done  <= 1'b0;
      k     <= '0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == cbrf_pkg::EV_IDLE && start) begin
        k <= '0;
      end else if (state == cbrf_pkg::EV_WAIT && mul_done) begin
        k <= k + 1'b1;
        if (k == LastTerm) done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == cbrf_pkg::EV_IDLE && start) begin
      h <= {{(cbrf_pkg::AccW-cbrf_pkg::XW){coef.a[cbrf_pkg::XW-1]}}, coef.a};
    end else if (state == cbrf_pkg::EV_WAIT && mul_done) begin
      h <= product + addend;
    end
  end

  assign f = h;

endmodule
